// ===== rtl/rle_mask_vertical_flip_macros.svh =====
// assertion macros for the flip block datapath (rmvf_dp)
// expects clk and rst_n in the scope of each use
`ifndef RLE_MASK_VERTICAL_FLIP_MACROS_SVH
`define RLE_MASK_VERTICAL_FLIP_MACROS_SVH

// same-cycle implication
`define RMVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define RMVF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/rmvf_pkg.sv =====
// shared types and constants of the mask vertical flip block
// used by rmvf_ctrl, rmvf_dp and rle_mask_vertical_flip
package rmvf_pkg;

  // configuration register
  localparam int          CFG_H_BITS         = 13;
  localparam logic [12:0] CFG_H_RESET        = 13'd1;
  localparam int          APB_ADDR_BITS      = 2;
  localparam int          APB_DATA_BITS      = 32;
  localparam logic [1:0]  ADDR_COLUMN_HEIGHT = 2'd0;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  // datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILL,
    OP_DTOP,
    OP_DMEM,
    OP_SPLIT,
    OP_DIV,
    OP_COLS,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;     // output register can take an item this cycle
    logic fill_active;  // run continues a partly filled column
    logic overflow;     // a new segment would not fit on the stack
    logic fill_full;    // the column completes with this run
    logic drain_one;    // only the top segment is on the stack
    logic idx_zero;     // drain reached the bottom segment
    logic split_long;   // remaining run covers at least one column
    logic div_last;     // final remainder step
  } sts_t;

endpackage

// ===== rtl/rmvf_ctrl.sv =====
// sequencer of the mask vertical flip block
// depends on rmvf_pkg for the command and status structs
module rmvf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rmvf_pkg::sts_t    sts,
  output rmvf_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FILL   = 8'b0000_0010,
    S_DTOP   = 8'b0000_0100,
    S_DMEM   = 8'b0000_1000,
    S_SPLIT  = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_COLS   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rmvf_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rmvf_pkg::OP_LOAD;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (sts.out_free) begin
          cmd.op = rmvf_pkg::OP_FILL;
          priority if (sts.fill_active && sts.overflow) begin
            state_nxt = S_IDLE;
          end else if (sts.fill_active && sts.fill_full) begin
            state_nxt = S_DTOP;
          end else begin
            state_nxt = S_SPLIT;
          end
        end
      end
      S_DTOP: begin
        if (sts.out_free) begin
          cmd.op    = rmvf_pkg::OP_DTOP;
          state_nxt = sts.drain_one ? S_SPLIT : S_DMEM;
        end
      end
      S_DMEM: begin
        if (sts.out_free) begin
          cmd.op = rmvf_pkg::OP_DMEM;
          if (sts.idx_zero) begin
            state_nxt = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        cmd.op    = rmvf_pkg::OP_SPLIT;
        state_nxt = sts.split_long ? S_DIV : S_FINISH;
      end
      S_DIV: begin
        cmd.op = rmvf_pkg::OP_DIV;
        if (sts.div_last) begin
          state_nxt = S_COLS;
        end
      end
      S_COLS: begin
        if (sts.out_free) begin
          cmd.op    = rmvf_pkg::OP_COLS;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.op    = rmvf_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/rmvf_dp.sv =====
// datapath of the mask vertical flip block: segment stack, remainder
// divider, merge of output runs and output register; uses rmvf_pkg
`include "rle_mask_vertical_flip_macros.svh"

module rmvf_dp #(
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_SEGMENTS = 62,
  parameter int RUN_BITS     = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rmvf_pkg::cmd_t                     cmd,
  output rmvf_pkg::sts_t                     sts,
  input  logic                               cfg_clear,
  input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  h_eff,
  input  logic [RUN_BITS-1:0]                in_run_length,
  input  logic                               in_last_run,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [RUN_BITS-1:0]                out_flipped_run_length,
  output logic                               out_last_out,
  output logic [1:0]                         out_status
);

  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int LW   = (RUN_BITS > HW) ? RUN_BITS : HW;
  localparam int AW   = $clog2(MAX_SEGMENTS);
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int DCW  = $clog2(RUN_BITS + 1);
  localparam logic [LW:0] RUN_MAX_X = {{(LW + 1 - RUN_BITS){1'b0}}, {RUN_BITS{1'b1}}};

  // current item
  logic [RUN_BITS-1:0] len_r, len_nxt;
  logic                last_r, last_nxt;
  logic                v_r, v_nxt;
  logic                cur_val_r, cur_val_nxt;
  // column and stack
  logic [HW-1:0]       row_r, row_nxt;
  logic [CNTW-1:0]     count_r, count_nxt;
  logic [HW-1:0]       top_len_r, top_len_nxt;
  logic                top_val_r, top_val_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                par_r, par_nxt;
  logic [HW-1:0]       seg_mem [MAX_SEGMENTS];
  logic [HW-1:0]       rd_data_r;
  // remainder divider
  logic [HW-1:0]       rem_r, rem_nxt;
  logic [RUN_BITS-1:0] dvd_r, dvd_nxt;
  logic [DCW-1:0]      dcnt_r, dcnt_nxt;
  // held-back output run
  logic [RUN_BITS-1:0] pend_len_r, pend_len_nxt;
  logic                pend_val_r, pend_val_nxt;
  logic                first_done_r, first_done_nxt;
  // output register
  logic                out_valid_r;
  logic [RUN_BITS-1:0] out_len_r;
  logic                out_last_r;
  logic [1:0]          out_status_r;

  logic                push_en, push_val;
  logic [HW-1:0]       push_len;
  logic                emit_en, emit_val;
  logic [LW-1:0]       emit_len;
  logic                put_en, put_last;
  logic [RUN_BITS-1:0] put_len;
  logic [1:0]          put_status;
  logic                rd_en, wr_en, clear_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [HW-1:0]       wr_data;

  logic [LW-1:0]       len_x, room_x, t_x, h_x;
  logic [HW-1:0]       room, t;
  logic [HW:0]         trial, diff;
  logic [HW-1:0]       rem_step;
  logic                out_free;

  assign len_x  = LW'(len_r);
  assign h_x    = LW'(h_eff);
  assign room   = h_eff - row_r;
  assign room_x = LW'(room);
  assign t_x    = (len_x < room_x) ? len_x : room_x;
  assign t      = t_x[HW-1:0];

  // one restoring step of len mod h
  assign trial    = {rem_r, dvd_r[RUN_BITS-1]};
  assign diff     = trial - {1'b0, h_eff};
  assign rem_step = (trial >= {1'b0, h_eff}) ? diff[HW-1:0] : trial[HW-1:0];

  assign out_free = !out_valid_r || !out_stall;

  assign sts.out_free    = out_free;
  assign sts.fill_active = (len_r != '0) && (row_r != '0);
  assign sts.overflow    = (count_r == CNTW'(MAX_SEGMENTS)) && (top_val_r != v_r);
  assign sts.fill_full   = (len_x >= room_x);
  assign sts.drain_one   = (count_r == CNTW'(1));
  assign sts.idx_zero    = (idx_r == '0);
  assign sts.split_long  = (len_x >= h_x);
  assign sts.div_last    = (dcnt_r == DCW'(1));

  always_comb begin
    logic [LW:0] len_ext;
    logic [LW:0] sum_x;
    logic [RUN_BITS-1:0] sat_len, sat_sum;

    len_nxt        = len_r;
    last_nxt       = last_r;
    v_nxt          = v_r;
    cur_val_nxt    = cur_val_r;
    row_nxt        = row_r;
    count_nxt      = count_r;
    top_len_nxt    = top_len_r;
    top_val_nxt    = top_val_r;
    idx_nxt        = idx_r;
    par_nxt        = par_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    dcnt_nxt       = dcnt_r;
    pend_len_nxt   = pend_len_r;
    pend_val_nxt   = pend_val_r;
    first_done_nxt = first_done_r;
    push_en        = 1'b0;
    push_val       = v_r;
    push_len       = '0;
    emit_en        = 1'b0;
    emit_val       = v_r;
    emit_len       = '0;
    put_en         = 1'b0;
    put_len        = '0;
    put_last       = 1'b0;
    put_status     = rmvf_pkg::ST_OK;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = top_len_r;
    clear_en       = 1'b0;

    unique case (cmd.op)
      rmvf_pkg::OP_NONE: begin
      end
      rmvf_pkg::OP_LOAD: begin
        len_nxt  = in_run_length;
        last_nxt = in_last_run;
        v_nxt    = cur_val_r;
      end
      rmvf_pkg::OP_FILL: begin
        if (sts.fill_active) begin
          if (sts.overflow) begin
            put_en     = 1'b1;
            put_last   = 1'b1;
            put_status = rmvf_pkg::ST_OVERFLOW;
            clear_en   = 1'b1;
          end else begin
            push_en  = 1'b1;
            push_len = t;
            row_nxt  = row_r + t;
            len_nxt  = len_r - RUN_BITS'(t_x);
          end
        end
      end
      rmvf_pkg::OP_DTOP: begin
        emit_en  = 1'b1;
        emit_val = top_val_r;
        emit_len = LW'(top_len_r);
        if (sts.drain_one) begin
          count_nxt = '0;
          row_nxt   = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(count_r - CNTW'(2));
          idx_nxt = AW'(count_r - CNTW'(2));
          par_nxt = 1'b1;
        end
      end
      rmvf_pkg::OP_DMEM: begin
        emit_en  = 1'b1;
        emit_val = top_val_r ^ par_r;
        emit_len = LW'(rd_data_r);
        if (sts.idx_zero) begin
          count_nxt = '0;
          row_nxt   = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(1);
          idx_nxt = idx_r - AW'(1);
          par_nxt = ~par_r;
        end
      end
      rmvf_pkg::OP_SPLIT: begin
        if (sts.split_long) begin
          rem_nxt  = '0;
          dvd_nxt  = len_r;
          dcnt_nxt = DCW'(RUN_BITS);
        end else if (len_r != '0) begin
          // shorter than a column: starts a new partial column
          push_en  = 1'b1;
          push_len = len_x[HW-1:0];
          row_nxt  = len_x[HW-1:0];
        end
      end
      rmvf_pkg::OP_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[RUN_BITS-2:0], 1'b0};
        dcnt_nxt = dcnt_r - DCW'(1);
      end
      rmvf_pkg::OP_COLS: begin
        // whole columns pass through as one block
        emit_en  = 1'b1;
        emit_len = len_x - LW'(rem_r);
        if (rem_r != '0) begin
          push_en  = 1'b1;
          push_len = rem_r;
          row_nxt  = rem_r;
        end
      end
      rmvf_pkg::OP_FINISH: begin
        cur_val_nxt = ~v_r;
        if (last_r) begin
          put_en   = 1'b1;
          put_last = 1'b1;
          priority if (row_r != '0) begin
            put_status = rmvf_pkg::ST_INCOMPLETE;
          end else if (!first_done_r) begin
            put_status = rmvf_pkg::ST_OK;
          end else begin
            put_len = pend_len_r;
          end
          clear_en = 1'b1;
        end
      end
    endcase

    // merge into the held-back run, saturating
    len_ext = {1'b0, emit_len};
    sum_x   = (LW + 1)'(pend_len_r) + len_ext;
    sat_len = (len_ext > RUN_MAX_X) ? RUN_MAX_X[RUN_BITS-1:0] : len_ext[RUN_BITS-1:0];
    sat_sum = (sum_x > RUN_MAX_X) ? RUN_MAX_X[RUN_BITS-1:0] : sum_x[RUN_BITS-1:0];
    if (emit_en && (emit_len != '0)) begin
      if (!first_done_r) begin
        // leading zero run is empty when the mask starts with ones
        put_en         = emit_val;
        pend_val_nxt   = emit_val;
        pend_len_nxt   = sat_len;
        first_done_nxt = 1'b1;
      end else if (emit_val == pend_val_r) begin
        pend_len_nxt = sat_sum;
      end else begin
        put_en       = 1'b1;
        put_len      = pend_len_r;
        pend_val_nxt = emit_val;
        pend_len_nxt = sat_len;
      end
    end

    // top segment lives in a register, the rest in the stack memory
    if (push_en) begin
      if ((count_r != '0) && (top_val_r == push_val)) begin
        top_len_nxt = top_len_r + push_len;
      end else begin
        wr_en       = (count_r != '0);
        wr_addr     = AW'(count_r - CNTW'(1));
        top_len_nxt = push_len;
        top_val_nxt = push_val;
        count_nxt   = count_r + CNTW'(1);
      end
    end

    if (clear_en || cfg_clear) begin
      count_nxt      = '0;
      row_nxt        = '0;
      cur_val_nxt    = 1'b0;
      first_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= seg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_val_r    <= 1'b0;
      row_r        <= '0;
      count_r      <= '0;
      first_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_val_r    <= cur_val_nxt;
      row_r        <= row_nxt;
      count_r      <= count_nxt;
      first_done_r <= first_done_nxt;
      if (put_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    last_r     <= last_nxt;
    v_r        <= v_nxt;
    top_len_r  <= top_len_nxt;
    top_val_r  <= top_val_nxt;
    idx_r      <= idx_nxt;
    par_r      <= par_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    dcnt_r     <= dcnt_nxt;
    pend_len_r <= pend_len_nxt;
    pend_val_r <= pend_val_nxt;
    if (put_en) begin
      out_len_r    <= put_len;
      out_last_r   <= put_last;
      out_status_r <= put_status;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_flipped_run_length = out_len_r;
  assign out_last_out           = out_last_r;
  assign out_status             = out_status_r;

  `RMVF_ASSERT_IMP(a_row_bound, 1'b1, row_r <= h_eff)
  `RMVF_ASSERT_IMP(a_stack_needs_rows, count_r != '0, row_r != '0)
  `RMVF_ASSERT_IMP(a_no_overwrite, put_en, !out_valid_r || !out_stall)
  `RMVF_ASSERT_NXT(a_drain_empties, (cmd.op == rmvf_pkg::OP_DTOP) && sts.drain_one, count_r == '0)

endmodule

// ===== rtl/rle_mask_vertical_flip.sv =====
// top level of the column-major run-length mask vertical flip
// holds the column height register; uses rmvf_pkg, rmvf_ctrl, rmvf_dp
//
//   channel  handshake          payload
//   in       in_valid/in_stall  in_run_length, in_last_run
//   out      out_valid/out_stall out_flipped_run_length, out_last_out, out_status
//   cfg      psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// one item at a time: a run inside a column steps through accept, fill, split and finish
// a run that completes a column also drains each stacked segment in turn (stack memory read port)
// a run of at least one column also steps through the remainder divider
// reset is synchronous; the stack memory is not cleared, only entries below the count are read
// out_stall holds the sequencer only in steps that can produce an item
module rle_mask_vertical_flip #(
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_SEGMENTS = 62,
  parameter int RUN_BITS     = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [RUN_BITS-1:0]                    in_run_length,
  input  logic                                   in_last_run,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [RUN_BITS-1:0]                    out_flipped_run_length,
  output logic                                   out_last_out,
  output logic [1:0]                             out_status,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rmvf_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [rmvf_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [rmvf_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                   pready
);

  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int XW = (HW > rmvf_pkg::CFG_H_BITS) ? HW : rmvf_pkg::CFG_H_BITS;

  logic [rmvf_pkg::CFG_H_BITS-1:0] column_height_r;
  logic [XW-1:0]                   ch_x;
  logic [HW-1:0]                   h_eff;
  logic                            reg_hit, cfg_wr;
  rmvf_pkg::cmd_t                  cmd;
  rmvf_pkg::sts_t                  sts;

  assign reg_hit = (paddr == rmvf_pkg::ADDR_COLUMN_HEIGHT);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? rmvf_pkg::APB_DATA_BITS'(column_height_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_height_r <= rmvf_pkg::CFG_H_RESET;
    end else if (cfg_wr) begin
      column_height_r <= pwdata[rmvf_pkg::CFG_H_BITS-1:0];
    end
  end

  // zero acts as one, heights beyond the limit clamp to it
  assign ch_x = XW'(column_height_r);
  always_comb begin
    priority if (ch_x == '0) begin
      h_eff = HW'(1);
    end else if (ch_x > XW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(ch_x);
    end
  end

  rmvf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmvf_dp #(
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .RUN_BITS     (RUN_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_clear              (cfg_wr),
    .h_eff                  (h_eff),
    .in_run_length          (in_run_length),
    .in_last_run            (in_last_run),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_flipped_run_length (out_flipped_run_length),
    .out_last_out           (out_last_out),
    .out_status             (out_status)
  );

endmodule

// ===== tb/tb_rle_mask_vertical_flip.sv =====
// self-checking testbench for rle_mask_vertical_flip: feeds masks as run lengths,
// predicts the flipped run-length code per item and checks every result item
// depends on rmvf_pkg and the rle_mask_vertical_flip rtl
module tb_rle_mask_vertical_flip;

  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_SEGMENTS = 62;
  localparam int RUN_BITS     = 24;
  localparam longint unsigned RUN_MAX = (64'd1 << RUN_BITS) - 64'd1;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;

  typedef struct packed {
    logic [RUN_BITS-1:0] len;
    logic                last;
    logic [1:0]          status;
  } flip_run_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [RUN_BITS-1:0]                in_run_length = '0;
  logic                               in_last_run = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [RUN_BITS-1:0]                out_flipped_run_length;
  logic                               out_last_out;
  logic [1:0]                         out_status;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [rmvf_pkg::APB_ADDR_BITS-1:0] paddr = '0;
  logic [rmvf_pkg::APB_DATA_BITS-1:0] pwdata = '0;
  logic [rmvf_pkg::APB_DATA_BITS-1:0] prdata;
  logic                               pready;

  rle_mask_vertical_flip #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .RUN_BITS(RUN_BITS)
  ) dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // flip predictor state
  logic [rmvf_pkg::CFG_H_BITS-1:0] height_reg;
  longint unsigned       seg_len [MAX_SEGMENTS];
  int unsigned           seg_count;
  longint unsigned       row_pos;
  bit                    cur_val;
  bit                    top_val;
  bit                    pend_val;
  bit                    pend_valid;
  longint unsigned       pend_len;

  flip_run_t flipped_runs_due[$];

  int  mismatches = 0;
  int  runs_sent = 0;
  int  results_seen = 0;
  int  heights_written = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  int  quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic void clear_flip_state();
    foreach (seg_len[i]) seg_len[i] = 0;
    seg_count  = 0;
    row_pos    = 0;
    cur_val    = 1'b0;
    top_val    = 1'b0;
    pend_val   = 1'b0;
    pend_valid = 1'b0;
    pend_len   = 0;
  endfunction

  function automatic void queue_run(input longint unsigned len, input bit last,
                                    input logic [1:0] status);
    flip_run_t r;
    r.len    = len[RUN_BITS-1:0];
    r.last   = last;
    r.status = status;
    flipped_runs_due.push_back(r);
  endfunction

  // output runs are held back one step so equal neighbors can merge
  function automatic void merge_out(input bit val, input longint unsigned len);
    if (len == 0) return;
    if (!pend_valid) begin
      if (val) queue_run(0, 1'b0, rmvf_pkg::ST_OK);
      pend_val   = val;
      pend_len   = (len > RUN_MAX) ? RUN_MAX : len;
      pend_valid = 1'b1;
    end else if (val == pend_val) begin
      pend_len += len;
      if (pend_len > RUN_MAX) pend_len = RUN_MAX;
    end else begin
      queue_run(pend_len, 1'b0, rmvf_pkg::ST_OK);
      pend_val = val;
      pend_len = (len > RUN_MAX) ? RUN_MAX : len;
    end
  endfunction

  function automatic bit stack_piece(input bit val, input longint unsigned len);
    if (seg_count > 0 && top_val == val) begin
      seg_len[seg_count-1] += len;
      return 1'b1;
    end
    if (seg_count >= MAX_SEGMENTS) return 1'b0;
    seg_len[seg_count] = len;
    seg_count++;
    top_val = val;
    return 1'b1;
  endfunction

  // column complete: bottom piece goes out first
  function automatic void flush_column();
    for (int i = 0; i < seg_count; i++)
      merge_out(top_val ^ i[0], seg_len[seg_count-1-i]);
    seg_count = 0;
    row_pos   = 0;
  endfunction

  function automatic void predict_flip(input logic [RUN_BITS-1:0] run, input bit last);
    longint unsigned len;
    longint unsigned h;
    longint unsigned room;
    longint unsigned t;
    longint unsigned cols;
    bit              v;
    len = run;
    h   = eff_height();
    v   = cur_val;
    if (len > 0 && row_pos > 0) begin
      room = h - row_pos;
      t    = (len < room) ? len : room;
      if (!stack_piece(v, t)) begin
        queue_run(0, 1'b1, rmvf_pkg::ST_OVERFLOW);
        clear_flip_state();
        return;
      end
      row_pos += t;
      len     -= t;
      if (row_pos >= h) flush_column();
    end
    if (len > 0) begin
      cols = len / h;
      if (cols > 0) begin
        merge_out(v, cols * h);
        len -= cols * h;
      end
      if (len > 0) begin
        void'(stack_piece(v, len));
        row_pos = len;
      end
    end
    cur_val = ~v;
    if (last) begin
      if (row_pos != 0) queue_run(0, 1'b1, rmvf_pkg::ST_INCOMPLETE);
      else if (!pend_valid) queue_run(0, 1'b1, rmvf_pkg::ST_OK);
      else queue_run(pend_len, 1'b1, rmvf_pkg::ST_OK);
      clear_flip_state();
    end
  endfunction

  always @(posedge clk) begin : result_check
    flip_run_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (flipped_runs_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item len %0d last %0b status %0d",
                                  out_flipped_run_length, out_last_out, out_status));
      end else begin
        want = flipped_runs_due.pop_front();
        if (out_flipped_run_length !== want.len || out_last_out !== want.last ||
            out_status !== want.status)
          report_mismatch($sformatf("got len %0d last %0b status %0d, want len %0d last %0b status %0d",
                                    out_flipped_run_length, out_last_out, out_status,
                                    want.len, want.last, want.status));
      end
    end
  end

  // receiver: random stalls, or one long hold when asked
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d items still due",
               QUIET_LIMIT, flipped_runs_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_run(input logic [RUN_BITS-1:0] len, input bit last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_run_length <= len;
    in_last_run   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_flip(len, last);
    runs_sent++;
  endtask

  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (flipped_runs_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // write column_height while idle, then read it back
  task automatic set_height(input logic [rmvf_pkg::APB_DATA_BITS-1:0] data);
    logic [rmvf_pkg::APB_DATA_BITS-1:0] readback;
    drain_results(SETTLE_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rmvf_pkg::ADDR_COLUMN_HEIGHT;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    height_reg = data[rmvf_pkg::CFG_H_BITS-1:0];
    clear_flip_state();
    heights_written++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[rmvf_pkg::CFG_H_BITS-1:0] !== height_reg)
      report_mismatch($sformatf("column_height reads %0d, written %0d",
                                readback[rmvf_pkg::CFG_H_BITS-1:0], height_reg));
  endtask

  function automatic logic [rmvf_pkg::APB_DATA_BITS-1:0] pick_height();
    int unsigned sel;
    logic [rmvf_pkg::APB_DATA_BITS-1:0] h;
    sel = $urandom_range(99);
    if (sel < 50) h = $urandom_range(1, 8);
    else if (sel < 75) h = $urandom_range(9, 64);
    else if (sel < 88) h = $urandom_range(65, MAX_HEIGHT);
    else if (sel < 92) h = 0;
    else if (sel < 96) h = MAX_HEIGHT;
    else h = $urandom_range(MAX_HEIGHT + 1, 8191);
    // junk above the register width now and then
    if ($urandom_range(3) == 0) h = ($urandom() & ~32'h1FFF) | h;
    return h;
  endfunction

  function automatic logic [RUN_BITS-1:0] random_run_length();
    int unsigned sel;
    int unsigned h;
    sel = $urandom_range(99);
    h   = eff_height();
    if (sel < 15) return '0;
    if (sel < 55) return RUN_BITS'($urandom_range(1, h));
    if (sel < 75) return RUN_BITS'($urandom_range(1, 3 * h));
    if (sel < 85) return RUN_BITS'(h * $urandom_range(1, 4));
    if (sel < 95) return RUN_BITS'($urandom_range(1, 8));
    return RUN_BITS'($urandom());
  endfunction

  task automatic test_directed_cases();
    set_height(1);
    send_run(0, 1'b1);                      // empty mask
    send_run(24'hFFFFFF, 1'b0);             // zero runs merge past an empty one run
    send_run(0, 1'b0);
    send_run(24'hFFFFFF, 1'b1);
    send_run(0, 1'b0);                      // mask opening with ones
    send_run(5, 1'b1);
    set_height(0);                          // behaves as one row
    send_run(3, 1'b0);
    send_run(2, 1'b1);
    set_height(4);
    send_run(2, 1'b0);                      // last column left partly filled
    send_run(3, 1'b1);
    send_run(1, 1'b0);
    send_run(2, 1'b0);
    send_run(1, 1'b0);
    send_run(4, 1'b1);
    set_height(8191);                       // clamps to the tallest column
    send_run(24'hFFFFFF, 1'b0);
    send_run(1, 1'b1);
    set_height(32'hFFFF_F000);              // upper bits dropped, 4096 rows
    send_run(4095, 1'b0);
    send_run(1, 1'b0);
    send_run(4096, 1'b1);
    set_height(6);
    send_run(2, 1'b0);
    send_run(3, 1'b0);
    set_height(3);                          // drops the unfinished mask
    send_run(3, 1'b0);
    send_run(3, 1'b1);
  endtask

  task automatic test_stack_limits();
    set_height(128);
    repeat (MAX_SEGMENTS + 1) send_run(1, 1'b0);   // one piece too many
    set_height(MAX_SEGMENTS);
    for (int i = 0; i < MAX_SEGMENTS; i++)         // exactly a full stack
      send_run(1, i == MAX_SEGMENTS - 1);
  endtask

  task automatic test_random_masks(input int run_budget);
    int              target;
    int              runs_in_mask;
    longint unsigned h;
    longint unsigned fill;
    target = runs_sent + run_budget;
    while (runs_sent < target) begin
      if ($urandom_range(3) == 0) set_height(pick_height());
      runs_in_mask = $urandom_range(0, 10);
      repeat (runs_in_mask) send_run(random_run_length(), 1'b0);
      // mostly close the mask on a column boundary
      h = eff_height();
      if ($urandom_range(9) < 8) begin
        fill = (row_pos == 0) ? 0 : h - row_pos;
        fill += h * $urandom_range(0, 2);
      end else begin
        fill = random_run_length();
      end
      send_run(fill[RUN_BITS-1:0], 1'b1);
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_receiver_hold();
    int saved_idle;
    longint unsigned fill;
    saved_idle = idle_pct;
    set_height(3);
    idle_pct     = 0;
    hold_request = 1'b1;
    repeat (24) send_run(RUN_BITS'($urandom_range(1, 4)), 1'b0);
    fill = (row_pos == 0) ? 3 : 3 - row_pos;
    send_run(fill[RUN_BITS-1:0], 1'b1);
    drain_results(SETTLE_CYCLES);
    idle_pct = saved_idle;
  endtask

  initial begin
    height_reg = rmvf_pkg::CFG_H_RESET;
    clear_flip_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    idle_pct = 29; stall_pct = 29;
    test_stack_limits();
    idle_pct = 0;  stall_pct = 0;
    test_random_masks(18);
    idle_pct = 63; stall_pct = 0;
    test_random_masks(18);
    idle_pct = 0;  stall_pct = 63;
    test_random_masks(18);
    idle_pct = 29; stall_pct = 29;
    test_random_masks(18);
    test_receiver_hold();

    drain_results(SETTLE_CYCLES);
    $display("covered %0d input runs, %0d flipped runs checked, %0d height writes",
             runs_sent, results_seen, heights_written);
    $display("under no idling, sender gaps, receiver stalls, both, and one long hold");
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rmvf_pkg.sv
rtl/rmvf_ctrl.sv
rtl/rmvf_dp.sv
rtl/rle_mask_vertical_flip.sv
tb/tb_rle_mask_vertical_flip.sv
